/* hdl/ftbl_pkg.sv */
// Shared types and codes for the bidirectional flow table lookup unit.
// Used by the channel interfaces and the top level; depends on nothing.
package ftbl_pkg;

    localparam int SLOT_W = 6;

    // Item kinds.
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Address and port matching modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DST  = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;
    localparam logic [1:0] MODE_REV  = 2'd3;

    // Bits of match_flags.
    localparam int FLAG_TYPE  = 0;
    localparam int FLAG_KIND  = 1;
    localparam int FLAG_IDENT = 2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        conn_type;
        logic [7:0]        icmp_kind;
        logic [15:0]       icmp_ident;
        logic [31:0]       addr_a;
        logic [31:0]       addr_b;
        logic [15:0]       port_a;
        logic [15:0]       port_b;
        logic [2:0]        match_flags;
        logic [1:0]        addr_mode;
        logic [1:0]        port_mode;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] hit_slot;
        logic              from_responder;
    } rsp_t;

    // One table entry as it is stored in memory.
    typedef struct packed {
        logic        valid;
        logic [2:0]  conn_type;
        logic [7:0]  icmp_kind;
        logic [15:0] icmp_ident;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [15:0] port_a;
        logic [15:0] port_b;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/ftbl_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on ftbl_pkg for the payload types.
interface ftbl_req_if;
    import ftbl_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ftbl_rsp_if;
    import ftbl_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/ftbl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module ftbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/flow_table_bidirectional_lookup_unit.sv */
// Top level of the bidirectional flow table lookup unit.
// Depends on ftbl_pkg, ftbl_if (channel interfaces) and ftbl_ram (table storage).
//
// The flow table holds TABLE_ENTRIES entries in one RAM, valid bit included.
// After reset the unit clears every entry of the table and accepts no
// item until that pass is done. Every item produces exactly one response
// item. The response to a write or clear item is registered at the
// accepting edge. A search walks the table one entry per cycle through
// the RAM read port, stopping at the first match or after the last entry.
// A new request is taken once the previous item has finished and the
// response register is empty or being emptied in the same cycle.
module flow_table_bidirectional_lookup_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ftbl_req_if.sink  req,
    ftbl_rsp_if.source rsp
);
    import ftbl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    req_t             key_reg, key_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic             accept;
    logic             slot_in_range;
    logic             hit;
    logic             hit_rev;

    ftbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign slot_in_range = 32'(req.data.slot) < TABLE_ENTRIES;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Match of the search key against the entry currently on the RAM output.
    always_comb
    begin
        logic fwd_a, rev_a, a_ok, a_set, a_dir;
        logic p_nz, p_fwd, p_rev, p_ok, p_dir;
        logic flags_ok;

        fwd_a = (ram_rdata.addr_a == key_reg.addr_a) && (ram_rdata.addr_b == key_reg.addr_b);
        rev_a = (ram_rdata.addr_b == key_reg.addr_a) && (ram_rdata.addr_a == key_reg.addr_b);

        flags_ok = !(key_reg.match_flags[FLAG_TYPE]
                     && (ram_rdata.conn_type != key_reg.conn_type))
                && !(key_reg.match_flags[FLAG_KIND]
                     && (ram_rdata.icmp_kind != key_reg.icmp_kind))
                && !(key_reg.match_flags[FLAG_IDENT]
                     && (ram_rdata.icmp_ident != key_reg.icmp_ident));

        case (key_reg.addr_mode)
            MODE_DST:
            begin
                a_ok  = ram_rdata.addr_b == key_reg.addr_b;
                a_set = 1'b1;
                a_dir = 1'b0;
            end
            MODE_BOTH:
            begin
                a_ok  = fwd_a;
                a_set = 1'b1;
                a_dir = 1'b0;
            end
            MODE_REV:
            begin
                a_ok  = fwd_a || rev_a;
                a_set = 1'b1;
                a_dir = !fwd_a;
            end
            default:
            begin
                a_ok  = 1'b1;
                a_set = 1'b0;
                a_dir = 1'b0;
            end
        endcase

        // A port of zero in the entry counts as missing.
        p_nz  = (ram_rdata.port_a != 16'd0) && (ram_rdata.port_b != 16'd0);
        p_fwd = (ram_rdata.port_a == key_reg.port_a) && (ram_rdata.port_b == key_reg.port_b)
                && (!a_set || !a_dir);
        p_rev = (ram_rdata.port_b == key_reg.port_a) && (ram_rdata.port_a == key_reg.port_b)
                && (!a_set || a_dir);

        case (key_reg.port_mode)
            MODE_DST:
            begin
                p_ok  = (ram_rdata.port_b != 16'd0) && (ram_rdata.port_b == key_reg.port_b)
                        && !(a_set && a_dir);
                p_dir = 1'b0;
            end
            MODE_BOTH:
            begin
                p_ok  = p_nz && (ram_rdata.port_a == key_reg.port_a)
                        && (ram_rdata.port_b == key_reg.port_b) && !(a_set && a_dir);
                p_dir = 1'b0;
            end
            MODE_REV:
            begin
                p_ok  = p_nz && (p_fwd || p_rev);
                p_dir = !p_fwd;
            end
            default:
            begin
                p_ok  = 1'b1;
                p_dir = a_dir;
            end
        endcase

        hit     = ram_rdata.valid && flags_ok && a_ok && p_ok;
        hit_rev = p_dir;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        ram_raddr      = idx_reg + IDX_W'(1);

        case (state_reg)
            ST_INIT:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = '0;
                ram_waddr = IDX_W'(req.data.slot);
                if (accept)
                begin
                    case (req.data.kind)
                        KIND_WRITE:
                        begin
                            ram_we               = slot_in_range;
                            ram_wdata.valid      = 1'b1;
                            ram_wdata.conn_type  = req.data.conn_type;
                            ram_wdata.icmp_kind  = req.data.icmp_kind;
                            ram_wdata.icmp_ident = req.data.icmp_ident;
                            ram_wdata.addr_a     = req.data.addr_a;
                            ram_wdata.addr_b     = req.data.addr_b;
                            ram_wdata.port_a     = req.data.port_a;
                            ram_wdata.port_b     = req.data.port_b;
                            rsp_valid_next       = 1'b1;
                            rsp_data_next        = '0;
                        end
                        KIND_CLEAR:
                        begin
                            ram_we         = slot_in_range;
                            rsp_valid_next = 1'b1;
                            rsp_data_next  = '0;
                        end
                        KIND_SEARCH:
                        begin
                            key_next   = req.data;
                            idx_next   = '0;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // The RAM output holds entry idx_reg; the next entry is read meanwhile.
                if (hit)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_data_next.found           = 1'b1;
                    rsp_data_next.hit_slot        = SLOT_W'(idx_reg);
                    rsp_data_next.from_responder  = hit_rev;
                    state_next                    = ST_IDLE;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_INIT;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            key_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            key_reg       <= key_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

endmodule

/* verif/tb_flow_table_bidirectional_lookup_unit.sv */
// Self-checking testbench for the bidirectional flow table lookup unit.
// Depends on ftbl_pkg, the ftbl_req_if/ftbl_rsp_if channels and the unit itself;
// a directed table runs first, then random table traffic under four phases of request idling and response stalls.
module tb_flow_table_bidirectional_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ftbl_pkg::*;

    localparam int TABLE_ENTRIES   = 64;
    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_ITEMS    = 950;
    localparam int PHASES          = 4;
    localparam int DRAIN_CYCLES    = TABLE_ENTRIES + 16;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_REPORTS     = 10;

    // The fourth kind code is not used by the unit; it must change nothing.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam rsp_t NO_RESULT = '0;
    localparam rsp_t SLOT0_HIT = {1'b1, 6'd0, 1'b0};

    typedef struct packed {
        req_t item;
        logic known;
        rsp_t answer;
    } stim_row_t;

    typedef struct packed {
        logic known;
        rsp_t answer;
    } typed_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    ftbl_req_if req_ch();
    ftbl_rsp_if rsp_ch();

    flow_table_bidirectional_lookup_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    entry_t        flow_tbl[TABLE_ENTRIES];
    rsp_t          lookup_expect_q[$];
    typed_answer_t typed_q[$];
    stim_row_t     directed_rows[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // Entry comparison for one slot; rev returns the direction of the match.
    function automatic logic key_matches(input entry_t e, input req_t k, output logic rev);
        logic settled;
        logic dir;
        settled = 1'b0;
        dir = 1'b0;
        rev = 1'b0;
        if (k.match_flags[FLAG_TYPE] && e.conn_type != k.conn_type) return 1'b0;
        if (k.match_flags[FLAG_KIND] && e.icmp_kind != k.icmp_kind) return 1'b0;
        if (k.match_flags[FLAG_IDENT] && e.icmp_ident != k.icmp_ident) return 1'b0;

        case (k.addr_mode)
            MODE_DST:
            begin
                if (e.addr_b != k.addr_b) return 1'b0;
                settled = 1'b1;
            end
            MODE_BOTH:
            begin
                if (e.addr_a != k.addr_a || e.addr_b != k.addr_b) return 1'b0;
                settled = 1'b1;
            end
            MODE_REV:
            begin
                if (e.addr_a == k.addr_a && e.addr_b == k.addr_b) begin
                    settled = 1'b1;
                end else if (e.addr_b == k.addr_a && e.addr_a == k.addr_b) begin
                    settled = 1'b1;
                    dir = 1'b1;
                end else begin
                    return 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // The direction is only ever 1 once settled, so "dir" alone tells
        // whether the address stage chose the reverse direction.
        case (k.port_mode)
            MODE_DST:
            begin
                if (e.port_b == 16'd0 || e.port_b != k.port_b) return 1'b0;
                if (dir) return 1'b0;
                settled = 1'b1;
            end
            MODE_BOTH:
            begin
                if (e.port_a == 16'd0 || e.port_b == 16'd0) return 1'b0;
                if (e.port_a != k.port_a || e.port_b != k.port_b) return 1'b0;
                if (dir) return 1'b0;
                settled = 1'b1;
            end
            MODE_REV:
            begin
                if (e.port_a == 16'd0 || e.port_b == 16'd0) return 1'b0;
                if (e.port_a == k.port_a && e.port_b == k.port_b && !dir) begin
                    settled = 1'b1;
                end else if (e.port_b == k.port_a && e.port_a == k.port_b
                             && (!settled || dir)) begin
                    settled = 1'b1;
                    dir = 1'b1;
                end else begin
                    return 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        rev = dir;
        return 1'b1;
    endfunction

    // Applies one accepted item to the shadow table and returns its result.
    function automatic rsp_t apply_flow_item(input req_t r);
        rsp_t   res;
        entry_t e;
        logic   rev;
        res = NO_RESULT;
        rev = 1'b0;
        case (r.kind)
            KIND_WRITE:
            begin
                e.valid      = 1'b1;
                e.conn_type  = r.conn_type;
                e.icmp_kind  = r.icmp_kind;
                e.icmp_ident = r.icmp_ident;
                e.addr_a     = r.addr_a;
                e.addr_b     = r.addr_b;
                e.port_a     = r.port_a;
                e.port_b     = r.port_b;
                flow_tbl[r.slot] = e;
            end
            KIND_CLEAR:
            begin
                flow_tbl[r.slot].valid = 1'b0;
            end
            KIND_SEARCH:
            begin
                for (int i = 0; i < TABLE_ENTRIES && !res.found; i++) begin
                    if (flow_tbl[i].valid && key_matches(flow_tbl[i], r, rev)) begin
                        res.found          = 1'b1;
                        res.hit_slot       = i[SLOT_W-1:0];
                        res.from_responder = rev;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic req_t write_item(input logic [5:0] slot, input logic [2:0] ctype,
                                        input logic [7:0] ikind, input logic [15:0] iid,
                                        input logic [31:0] a, input logic [31:0] b,
                                        input logic [15:0] pa, input logic [15:0] pb);
        req_t r;
        r            = '0;
        r.kind       = KIND_WRITE;
        r.slot       = slot;
        r.conn_type  = ctype;
        r.icmp_kind  = ikind;
        r.icmp_ident = iid;
        r.addr_a     = a;
        r.addr_b     = b;
        r.port_a     = pa;
        r.port_b     = pb;
        return r;
    endfunction

    function automatic req_t search_item(input logic [2:0] ctype, input logic [7:0] ikind,
                                         input logic [15:0] iid,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input logic [15:0] pa, input logic [15:0] pb,
                                         input logic [2:0] flags,
                                         input logic [1:0] amode, input logic [1:0] pmode);
        req_t r;
        r             = write_item(6'($urandom_range(63)), ctype, ikind, iid, a, b, pa, pb);
        r.kind        = KIND_SEARCH;
        r.match_flags = flags;
        r.addr_mode   = amode;
        r.port_mode   = pmode;
        return r;
    endfunction

    function automatic req_t clear_item(input logic [5:0] slot);
        req_t r;
        r      = '0;
        r.kind = KIND_CLEAR;
        r.slot = slot;
        return r;
    endfunction

    // A small address and port pool makes reversed and repeated flows common.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        case ($urandom_range(9))
            0: a = 32'h0000_0000;
            1: a = 32'hFFFF_FFFF;
            2, 3, 4, 5, 6: a = 32'h0A00_0000 | $urandom_range(1, 4);
            default: a = $urandom;
        endcase
        return a;
    endfunction

    function automatic logic [15:0] pick_port();
        logic [15:0] p;
        case ($urandom_range(11))
            0: p = 16'd0;
            1: p = 16'hFFFF;
            2, 3, 4, 5, 6:
            begin
                case ($urandom_range(3))
                    0: p = 16'd53;
                    1: p = 16'd80;
                    2: p = 16'd443;
                    default: p = 16'd8080;
                endcase
            end
            default: p = 16'($urandom_range(65535));
        endcase
        return p;
    endfunction

    function automatic logic [7:0] pick_icmp_kind();
        return ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'd8;
    endfunction

    function automatic logic [15:0] pick_icmp_ident();
        return ($urandom_range(2) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(1, 3));
    endfunction

    function automatic req_t make_random_item();
        req_t        k;
        entry_t      e;
        int          pick;
        int          s;
        int          roll;
        logic [31:0] tmp_addr;
        logic [15:0] tmp_port;
        roll = $urandom_range(99);
        if (roll < 30) begin
            return write_item(6'($urandom_range(63)), 3'($urandom_range(7)), pick_icmp_kind(),
                              pick_icmp_ident(), pick_addr(), pick_addr(),
                              pick_port(), pick_port());
        end
        if (roll < 40) return clear_item(6'($urandom_range(63)));

        pick = -1;
        repeat (8) begin
            s = $urandom_range(TABLE_ENTRIES - 1);
            if (pick < 0 && flow_tbl[s].valid) pick = s;
        end
        if (pick < 0 || $urandom_range(99) < 20) begin
            return search_item(3'($urandom_range(7)), pick_icmp_kind(), pick_icmp_ident(),
                               pick_addr(), pick_addr(), pick_port(), pick_port(),
                               3'($urandom_range(7)), 2'($urandom_range(3)),
                               2'($urandom_range(3)));
        end

        // Key taken from a live entry, possibly seen from the other side.
        e = flow_tbl[pick];
        k = search_item(e.conn_type, e.icmp_kind, e.icmp_ident, e.addr_a, e.addr_b,
                        e.port_a, e.port_b, 3'($urandom_range(7)), 2'($urandom_range(3)),
                        2'($urandom_range(3)));
        roll = $urandom_range(9);
        if (roll >= 4 && roll <= 7) begin
            tmp_addr = k.addr_a;
            k.addr_a = k.addr_b;
            k.addr_b = tmp_addr;
        end
        if ((roll >= 4 && roll <= 6) || roll == 8) begin
            tmp_port = k.port_a;
            k.port_a = k.port_b;
            k.port_b = tmp_port;
        end
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: k.conn_type = 3'($urandom_range(7));
                1: k.icmp_kind = k.icmp_kind ^ (8'd1 << $urandom_range(7));
                2: k.icmp_ident = pick_icmp_ident();
                3: k.addr_a = pick_addr();
                default: k.port_a = pick_port();
            endcase
        end
        return k;
    endfunction

    task automatic add_row(input req_t item, input logic known, input rsp_t answer);
        stim_row_t row;
        row.item   = item;
        row.known  = known;
        row.answer = answer;
        directed_rows.push_back(row);
    endtask

    task automatic load_directed();
        req_t spare;
        // Empty table: nothing can match, even a key that ignores everything.
        add_row(search_item(0, 0, 0, 0, 0, 0, 0, 0, MODE_NONE, MODE_NONE), 1, NO_RESULT);
        add_row(search_item(7, 255, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 16'hFFFF, 7, MODE_REV, MODE_REV), 1, NO_RESULT);
        add_row(write_item(0, 7, 255, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd1),
                1, NO_RESULT);
        add_row(write_item(63, 0, 0, 0, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80),
                1, NO_RESULT);
        // Slot 5 has no side one port.
        add_row(write_item(5, 3, 8, 16'h1234, 32'hC0A8_0001, 32'hC0A8_0002, 16'd0, 16'd443),
                1, NO_RESULT);
        add_row(search_item(0, 0, 0, 0, 0, 0, 0, 0, MODE_NONE, MODE_NONE), 1, SLOT0_HIT);
        add_row(search_item(0, 0, 0, 0, 32'h0A00_0002, 0, 0, 0, MODE_DST, MODE_NONE),
                0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd1234, 0,
                            MODE_REV, MODE_REV), 0, NO_RESULT);
        // Reversed addresses against forward ports, and the other way round.
        add_row(search_item(0, 0, 0, 32'h0A00_0002, 32'h0A00_0001, 16'd1234, 16'd80, 0,
                            MODE_REV, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd1234, 0,
                            MODE_REV, MODE_REV), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 0,
                            MODE_REV, MODE_REV), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'hC0A8_0001, 32'hC0A8_0002, 16'd0, 16'd443, 0,
                            MODE_BOTH, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'h0000_0001, 32'hC0A8_0002, 16'd0, 16'd443, 0,
                            MODE_DST, MODE_DST), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 32'hC0A8_0002, 32'hC0A8_0001, 16'd443, 16'd0, 0,
                            MODE_REV, MODE_REV), 0, NO_RESULT);
        add_row(search_item(7, 255, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd1, 7,
                            MODE_BOTH, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(6, 255, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd1, 1,
                            MODE_BOTH, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(7, 254, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd1, 2,
                            MODE_BOTH, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(7, 255, 16'hFFFE, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd1, 4,
                            MODE_BOTH, MODE_BOTH), 0, NO_RESULT);
        add_row(search_item(0, 0, 0, 0, 0, 0, 16'd80, 0, MODE_NONE, MODE_DST), 0, NO_RESULT);
        // Direction settled by the ports alone.
        add_row(search_item(0, 0, 0, 0, 0, 16'd80, 16'd1234, 0, MODE_NONE, MODE_REV),
                0, NO_RESULT);
        add_row(clear_item(0), 1, NO_RESULT);
        add_row(search_item(0, 0, 0, 0, 0, 0, 0, 0, MODE_NONE, MODE_NONE), 0, NO_RESULT);
        spare = clear_item(5);
        spare.kind = KIND_SPARE;
        add_row(spare, 1, NO_RESULT);
        add_row(search_item(3, 8, 16'h1234, 32'hC0A8_0001, 32'hC0A8_0002, 0, 0, 7,
                            MODE_BOTH, MODE_NONE), 0, NO_RESULT);
        // A zero key port equal to a zero entry port still counts as missing.
        add_row(write_item(10, 1, 0, 0, 0, 0, 16'd1, 16'd0), 1, NO_RESULT);
        add_row(search_item(0, 0, 0, 0, 0, 16'd1, 16'd0, 0, MODE_NONE, MODE_DST),
                0, NO_RESULT);
    endtask

    task automatic offer(input req_t item, input logic known, input rsp_t answer);
        typed_answer_t note;
        note.known  = known;
        note.answer = answer;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        typed_q.push_back(note);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
    endtask

    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Results are checked before the same edge's request is predicted, so an
    // unexpected result can never be matched against a newer item.
    always @(posedge clk) begin
        typed_answer_t note;
        rsp_t          want;
        logic          moved;
        moved = 1'b0;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            moved = 1'b1;
            results_seen++;
            if (lookup_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: found=%0b slot=%0d rev=%0b",
                             results_seen, rsp_ch.data.found, rsp_ch.data.hit_slot,
                             rsp_ch.data.from_responder);
            end else begin
                want = lookup_expect_q.pop_front();
                if (rsp_ch.data.found !== want.found
                    || rsp_ch.data.hit_slot !== want.hit_slot
                    || rsp_ch.data.from_responder !== want.from_responder) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d mismatch: expected found=%0b slot=%0d rev=%0b, got found=%0b slot=%0d rev=%0b",
                                 results_seen, want.found, want.hit_slot, want.from_responder,
                                 rsp_ch.data.found, rsp_ch.data.hit_slot,
                                 rsp_ch.data.from_responder);
                end
            end
        end
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            moved = 1'b1;
            note = typed_q.pop_front();
            want = apply_flow_item(req_ch.data);
            lookup_expect_q.push_back(note.known ? note.answer : want);
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("tb_flow_table_bidirectional_lookup_unit failed");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) flow_tbl[i] = '0;
        load_directed();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
            offer(directed_rows[n].item, directed_rows[n].known, directed_rows[n].answer);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                offer(make_random_item(), 1'b0, NO_RESULT);
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (lookup_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && lookup_expect_q.size() == 0)
            $display("tb_flow_table_bidirectional_lookup_unit passed");
        else
            $display("tb_flow_table_bidirectional_lookup_unit failed");
        $finish;
    end

endmodule
